/* hdl/chfa_pkg.sv */
// Shared types and codes for the cell heap fit allocator.
package chfa_pkg;

	localparam logic [1:0] REQ_FIRST = 2'd0;
	localparam logic [1:0] REQ_BEST  = 2'd1;
	localparam logic [1:0] REQ_FREE  = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOSPACE  = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;

	typedef enum logic [1:0] {
		RS_DIRECT = 2'd0,
		RS_ALLOC  = 2'd1,
		RS_FREE   = 2'd2
	} res_sel_t;

	typedef struct packed {
		logic     capture;
		logic     scan_init;
		logic     scan_en;
		logic     fill_init;
		logic     fill_en;
		logic     free_init;
		logic     free_en;
		logic     res_load;
		res_sel_t res_sel;
	} cmd_t;

	typedef struct packed {
		logic req_alloc;
		logic req_free;
		logic trivial;
		logic scan_end;
		logic found;
		logic fill_last;
		logic free_done;
		logic slot_free;
	} sts_t;

endpackage

/* hdl/chfa_datapath.sv */
// Cell store, scan counter, run tracking and result register of the allocator.
module chfa_datapath #(
	parameter int CELLS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  chfa_pkg::cmd_t   cmd,
	output chfa_pkg::sts_t   sts,
	input  logic [1:0]       req_type,
	input  logic [7:0]       owner_id,
	input  logic [5:0]       alloc_size,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [1:0]       status,
	output logic [4:0]       start_address,
	output logic [5:0]       freed_count
);
	import chfa_pkg::*;

	localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int IW = AW + 1;
	localparam int CW = (IW > 6) ? IW : 6;
	localparam int SW = (AW > 5) ? AW : 5;
	localparam logic [IW-1:0] LAST = IW'(CELLS);

	logic [1:0]       req_q;
	logic [7:0]       id_q;
	logic [5:0]       size_q;
	logic [CELLS-1:0] used_q;
	logic [7:0]       owner_mem [CELLS];
	logic [IW-1:0]    idx_q;
	logic [AW-1:0]    run_start_q;
	logic [IW-1:0]    run_len_q;
	logic             found_q;
	logic [AW-1:0]    best_start_q;
	logic [IW-1:0]    best_len_q;
	logic [5:0]       cnt_q;
	logic [IW-1:0]    freed_q;
	logic             v_s1;
	logic             used_s1;
	logic [AW-1:0]    idx_s1;
	logic [7:0]       owner_s1;
	logic             out_valid_q;
	logic [1:0]       status_q;
	logic [4:0]       start_q;
	logic [5:0]       freed_out_q;

	logic          in_range;
	logic          used_rd;
	logic          is_free;
	logic          is_best;
	logic          cand;
	logic          hit_s1;
	logic [AW-1:0] addr;

	assign addr     = idx_q[AW-1:0];
	assign in_range = idx_q < LAST;
	assign used_rd  = in_range ? used_q[addr] : 1'b1;
	assign is_free  = !used_rd;
	assign is_best  = req_q == REQ_BEST;
	assign cand     = (run_len_q != '0) && !is_free
		&& (CW'(run_len_q) >= CW'(size_q))
		&& (!found_q || (is_best && (run_len_q < best_len_q)));
	assign hit_s1   = v_s1 && used_s1 && (owner_s1 == id_q);

	always_comb begin
		sts.req_alloc = (req_q == REQ_FIRST) || (req_q == REQ_BEST);
		sts.req_free  = req_q == REQ_FREE;
		sts.trivial   = (id_q == 8'd0) || (size_q == 6'd0);
		sts.scan_end  = (idx_q == LAST) || (cand && !is_best);
		sts.found     = found_q;
		sts.fill_last = cnt_q == 6'd1;
		sts.free_done = (idx_q == LAST) && !v_s1;
		sts.slot_free = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q  <= req_type;
			id_q   <= owner_id;
			size_q <= alloc_size;
		end
		if (cmd.scan_init || cmd.free_init) begin
			idx_q <= '0;
		end else if (cmd.fill_init) begin
			idx_q <= {1'b0, best_start_q};
		end else if (cmd.scan_en || cmd.fill_en || (cmd.free_en && in_range)) begin
			idx_q <= idx_q + 1'b1;
		end
		if (cmd.scan_init) begin
			run_len_q <= '0;
		end else if (cmd.scan_en) begin
			if (is_free) begin
				if (run_len_q == '0) begin
					run_start_q <= addr;
				end
				run_len_q <= run_len_q + 1'b1;
			end else begin
				run_len_q <= '0;
			end
		end
		if (cmd.scan_en && cand) begin
			best_start_q <= run_start_q;
			best_len_q   <= run_len_q;
		end
		if (cmd.fill_init) begin
			cnt_q <= size_q;
		end else if (cmd.fill_en) begin
			cnt_q <= cnt_q - 6'd1;
		end
		used_s1  <= used_rd;
		idx_s1   <= addr;
		owner_s1 <= owner_mem[addr];
		if (cmd.fill_en) begin
			owner_mem[addr] <= id_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			found_q     <= 1'b0;
			freed_q     <= '0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.fill_en) begin
				used_q[addr] <= 1'b1;
			end else if (hit_s1) begin
				used_q[idx_s1] <= 1'b0;
			end
			if (cmd.scan_init) begin
				found_q <= 1'b0;
			end else if (cmd.scan_en && cand) begin
				found_q <= 1'b1;
			end
			if (cmd.free_init) begin
				freed_q <= '0;
			end else if (hit_s1) begin
				freed_q <= freed_q + 1'b1;
			end
			v_s1 <= cmd.free_en && in_range;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			status_q    <= ST_OK;
			start_q     <= '0;
			freed_out_q <= '0;
			unique case (cmd.res_sel)
				RS_ALLOC: begin
					if (found_q) begin
						start_q <= 5'(SW'(best_start_q));
					end else begin
						status_q <= ST_NOSPACE;
					end
				end
				RS_FREE: begin
					freed_out_q <= 6'(CW'(freed_q));
					if (freed_q == '0) begin
						status_q <= ST_NOTFOUND;
					end
				end
				default: begin
					if (sts.req_alloc) begin
						status_q <= (id_q == 8'd0) ? ST_NOTFOUND : ST_NOSPACE;
					end
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign start_address = start_q;
	assign freed_count   = freed_out_q;

`ifndef SYNTHESIS
	a_fill_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fill_en |-> (idx_q < LAST) && !used_q[addr])
		else $error("fill writes outside a free run");
	a_freed_bound: assert property (@(posedge clk) disable iff (!arst_n)
		freed_q <= LAST)
		else $error("freed count exceeds heap size");
	a_load_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> (!out_valid_q || !out_stall))
		else $error("result overwrites a pending transaction");
`endif

endmodule

/* hdl/chfa_ctrl.sv */
// Request sequencer of the allocator.
module chfa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  chfa_pkg::sts_t sts,
	output chfa_pkg::cmd_t cmd
);
	import chfa_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_DECODE = 7'b0000010,
		S_SCAN   = 7'b0000100,
		S_CHECK  = 7'b0001000,
		S_FILL   = 7'b0010000,
		S_FREE   = 7'b0100000,
		S_FIN    = 7'b1000000
	} state_t;

	state_t   state_q, state_d;
	res_sel_t sel_q, sel_d;

	always_comb begin
		state_d = state_q;
		sel_d   = sel_q;
		cmd     = '0;
		cmd.res_sel = sel_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.req_alloc && !sts.trivial) begin
					cmd.scan_init = 1'b1;
					state_d = S_SCAN;
				end else if (sts.req_free) begin
					cmd.free_init = 1'b1;
					state_d = S_FREE;
				end else begin
					sel_d   = RS_DIRECT;
					state_d = S_FIN;
				end
			end
			S_SCAN: begin
				cmd.scan_en = 1'b1;
				if (sts.scan_end) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				sel_d = RS_ALLOC;
				if (sts.found) begin
					cmd.fill_init = 1'b1;
					state_d = S_FILL;
				end else begin
					state_d = S_FIN;
				end
			end
			S_FILL: begin
				cmd.fill_en = 1'b1;
				if (sts.fill_last) begin
					state_d = S_FIN;
				end
			end
			S_FREE: begin
				cmd.free_en = 1'b1;
				if (sts.free_done) begin
					sel_d   = RS_FREE;
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (sts.slot_free) begin
					cmd.res_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_q   <= RS_DIRECT;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
		end
	end

	assign in_stall = state_q != S_IDLE;

`ifndef SYNTHESIS
	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_DECODE))
		else $error("accepted transaction not decoded");
	a_fill_after_find: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fill_init |-> sts.found && sts.req_alloc)
		else $error("fill started without a run");
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_FILL || state_q == S_FREE) |-> in_stall)
		else $error("input taken while busy");
`endif

endmodule

/* hdl/cell_heap_fit_allocator.sv */
// Top level of the cell heap fit allocator.
//
// Requests enter on the input channel (in_valid, in_stall, req_type, owner_id,
// alloc_size) and each produces one result transaction on the output channel
// (out_valid, out_stall, status, start_address, freed_count).
// One request is worked at a time; in_stall is high from acceptance until its
// result is loaded into the output register.
// Allocate: a decode step, a scan of the used bits one cell per cycle
// (first fit stops at the first run that fits), a check step, a fill
// step that writes the owner store for each allocated cell, and a step
// that loads the result.
// Free: decode, a pass through the owner memory (one read port,
// registered read) and a load step.
// Rejected or unknown requests go from decode straight to the load step.
// The sequencer passes through idle before it takes the next request.
// The output register holds a result while out_stall is high; the next
// request is accepted meanwhile and waits at its last step until the
// register frees. Reset marks every cell free at once; no clearing pass.
module cell_heap_fit_allocator #(
	parameter int CELLS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] req_type,
	input  logic [7:0] owner_id,
	input  logic [5:0] alloc_size,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] status,
	output logic [4:0] start_address,
	output logic [5:0] freed_count
);
	import chfa_pkg::*;

	cmd_t cmd;
	sts_t sts;

	chfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	chfa_datapath #(
		.CELLS (CELLS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.req_type      (req_type),
		.owner_id      (owner_id),
		.alloc_size    (alloc_size),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.start_address (start_address),
		.freed_count   (freed_count)
	);

endmodule
